// ===== hw/rtl/tdts_pkg.sv =====
// Shared types, constants and keyword tables for the token scanner.
`default_nettype none
package tdts_pkg;

   // keyword table size and result queue depth
   localparam int KW_TABLE = 14;
   localparam int QDEPTH   = 8;
   localparam int QPTR_W   = $clog2(QDEPTH);
   localparam int QCNT_W   = $clog2(QDEPTH + 1);

   // register indexes on the control port
   localparam logic [1:0] REG_MAX_ID  = 2'd0;
   localparam logic [1:0] REG_MAX_STR = 2'd1;
   localparam logic [1:0] REG_MAX_INT = 2'd2;

   // reset values of the limits
   localparam logic [7:0]  MAX_ID_RST  = 8'd30;
   localparam logic [7:0]  MAX_STR_RST = 8'd29;
   localparam logic [15:0] MAX_INT_RST = 16'hFFFF;

   // keyword spellings, right aligned, and their lengths
   localparam logic [79:0] KW_STR [KW_TABLE] = '{
      80'("while"), 80'("if"), 80'("const"), 80'("declare"), 80'("enddeclare"),
      80'("real"), 80'("int"), 80'("string"), 80'("main"), 80'("else"),
      80'("and"), 80'("or"), 80'("put"), 80'("get")
   };
   localparam logic [3:0] KW_LEN [KW_TABLE] = '{
      4'd5, 4'd2, 4'd5, 4'd7, 4'd10, 4'd4, 4'd3, 4'd6, 4'd4, 4'd4, 4'd3, 4'd2, 4'd3, 4'd3
   };

   typedef struct packed {
      logic [7:0]  max_id;
      logic [7:0]  max_str;
      logic [15:0] max_int;
   } cfg_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [3:0]  kw;
      logic [15:0] val;
      logic [7:0]  len;
      logic [2:0]  err;
      logic [15:0] line;
      logic        last;
   } tok_type;

   // character at position p of keyword i (p below its length)
   function automatic logic [7:0] kw_char(input int i, input logic [3:0] p);
      int idx;
      idx = int'(KW_LEN[i]) - 1 - int'(p);
      return KW_STR[i][idx*8 +: 8];
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tdts_csr.sv =====
// Control registers of the token scanner: three limits on an APB-style port.
`default_nettype none
module tdts_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [3:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic      [31:0]      csr_prdata,
   output logic                  csr_pready,
   output tdts_pkg::cfg_type     cfg
);
   tdts_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;
   logic [1:0]        idx;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   // decode a write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            tdts_pkg::REG_MAX_ID:  cfg_in.max_id  = csr_pwdata[7:0];
            tdts_pkg::REG_MAX_STR: cfg_in.max_str = csr_pwdata[7:0];
            tdts_pkg::REG_MAX_INT: cfg_in.max_int = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (idx)
         tdts_pkg::REG_MAX_ID:  csr_prdata = {24'd0, cfg_ff.max_id};
         tdts_pkg::REG_MAX_STR: csr_prdata = {24'd0, cfg_ff.max_str};
         tdts_pkg::REG_MAX_INT: csr_prdata = {16'd0, cfg_ff.max_int};
         default:               csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_id  <= tdts_pkg::MAX_ID_RST;
         cfg_ff.max_str <= tdts_pkg::MAX_STR_RST;
         cfg_ff.max_int <= tdts_pkg::MAX_INT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/tdts_lexer.sv =====
// Scanner state machine: one character per cycle, up to two tokens out.
`default_nettype none
module tdts_lexer #(
   parameter int NUM_KEYWORDS = 14
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [7:0]        in_char,
   input  wire logic              in_eoi,
   input  wire tdts_pkg::cfg_type cfg,
   output logic [1:0]             push_n,
   output tdts_pkg::tok_type      tok0,
   output tdts_pkg::tok_type      tok1
);
   localparam int KW_USED = (NUM_KEYWORDS < tdts_pkg::KW_TABLE) ? NUM_KEYWORDS
                                                                : tdts_pkg::KW_TABLE;
   localparam int KW = tdts_pkg::KW_TABLE;

   // token kinds
   localparam logic [4:0] K_PLUS = 5'd0,  K_MINUS = 5'd1,  K_MUL = 5'd2,   K_DIV = 5'd3;
   localparam logic [4:0] K_ASSIGN = 5'd4, K_EQ = 5'd5,   K_LT = 5'd6,    K_GT = 5'd7;
   localparam logic [4:0] K_GE = 5'd8,    K_LE = 5'd9,    K_COLON = 5'd10, K_NE = 5'd11;
   localparam logic [4:0] K_SEMI = 5'd12, K_LPAR = 5'd13, K_RPAR = 5'd14, K_COMMA = 5'd15;
   localparam logic [4:0] K_CONCAT = 5'd16, K_NOT = 5'd17, K_LBRACE = 5'd18;
   localparam logic [4:0] K_RBRACE = 5'd19, K_ID = 5'd20, K_KW = 5'd21, K_INT = 5'd22;
   localparam logic [4:0] K_REAL = 5'd23, K_STR = 5'd24, K_ERR = 5'd25;
   localparam logic [4:0] K_SINGLE_END = 5'd20;

   // error codes
   localparam logic [2:0] E_NONE = 3'd0, E_BAD = 3'd1, E_EOF_STR = 3'd2, E_EOF_CM = 3'd3;
   localparam logic [2:0] E_LONG_ID = 3'd4, E_LONG_STR = 3'd5, E_INT_OVF = 3'd6;

   // state codes
   localparam logic [5:0] ST_START = 6'd0, ST_ID = 6'd1, ST_INT = 6'd2, ST_REAL = 6'd3;
   localparam logic [5:0] ST_STR = 6'd4, ST_PLUS = 6'd5, ST_ASSIGN = 6'd6, ST_LESS = 6'd7;
   localparam logic [5:0] ST_GREATER = 6'd8, ST_BANG = 6'd9, ST_MINUS = 6'd10;
   localparam logic [5:0] ST_MINUS2 = 6'd11, ST_STR_DONE = 6'd12, ST_BAD = 6'd13;
   localparam logic [5:0] ST_CM = 6'd16, ST_CM_SL = 6'd17, ST_CM_SLM = 6'd18;
   localparam logic [5:0] ST_CM_M = 6'd19, ST_CM_MM = 6'd20, ST_NC = 6'd21;
   localparam logic [5:0] ST_NC_SL = 6'd22, ST_NC_SLM = 6'd23, ST_DONE = 6'd32;

   localparam logic [16:0] ACC_SAT = 17'd65536;

   typedef struct packed {
      logic [1:0]        n;
      tdts_pkg::tok_type a;
      tdts_pkg::tok_type b;
   } flush_type;

   typedef struct packed {
      logic [5:0]    st;
      logic [KW-1:0] kwb;
      logic [7:0]    len;
      logic [16:0]   acc;
   } start_type;

   logic [5:0]    st_ff, st_in;
   logic [KW-1:0] kwb_ff, kwb_in;
   logic [7:0]    len_ff, len_in;
   logic [16:0]   acc_ff, acc_in;
   logic [15:0]   line_ff, line_in;

   logic          is_let, is_dig, take;
   logic [7:0]    lc;
   logic [19:0]   acc_mul;
   flush_type     fl;
   start_type     sc;
   logic [1:0]    n;
   tdts_pkg::tok_type t0, t1;

   function automatic tdts_pkg::tok_type mk(input logic [4:0] kind, input logic [3:0] kw,
                                            input logic [15:0] val, input logic [7:0] len,
                                            input logic [2:0] err, input logic [15:0] line);
      tdts_pkg::tok_type t;
      t.kind = kind; t.kw = kw; t.val = val; t.len = len; t.err = err;
      t.line = line; t.last = 1'b0;
      return t;
   endfunction

   // clear match bits of keywords that do not fit character ch at position pos
   function automatic logic [KW-1:0] filt(input logic [KW-1:0] bits, input logic [7:0] pos,
                                          input logic [7:0] ch);
      logic [KW-1:0] r;
      r = bits;
      for (int i = 0; i < KW; i++) begin
         if (i < KW_USED) begin
            if (!(pos < {4'd0, tdts_pkg::KW_LEN[i]}) ||
                tdts_pkg::kw_char(i, pos[3:0]) != ch) r[i] = 1'b0;
         end
      end
      return r;
   endfunction

   assign is_let  = (in_char >= "a" && in_char <= "z") || (in_char >= "A" && in_char <= "Z");
   assign is_dig  = in_char >= "0" && in_char <= "9";
   assign lc      = (in_char >= "A" && in_char <= "Z") ? in_char + 8'd32 : in_char;
   assign acc_mul = {3'd0, acc_ff} * 20'd10 + {16'd0, in_char[3:0]};

   // tokens owed by the current state when its lexeme ends
   always_comb begin
      logic [3:0] kwi;
      logic       hit;
      kwi = 4'd0;
      hit = 1'b0;
      fl.n = 2'd0;
      fl.a = mk(K_ERR, 4'd0, 16'd0, 8'd0, E_NONE, line_ff);
      fl.b = mk(K_MINUS, 4'd0, 16'd0, 8'd0, E_NONE, line_ff);
      for (int i = KW - 1; i >= 0; i--) begin
         if (i < KW_USED && kwb_ff[i] && len_ff == {4'd0, tdts_pkg::KW_LEN[i]}) begin
            hit = 1'b1;
            kwi = 4'(i);
         end
      end
      if (st_ff[5] && st_ff[4:0] < K_SINGLE_END) begin
         fl.n = 2'd1;
         fl.a = mk(st_ff[4:0], 4'd0, 16'd0, 8'd0, E_NONE, line_ff);
      end else begin
         case (st_ff)
            ST_ID: begin
               fl.n = 2'd1;
               if (len_ff > cfg.max_id) fl.a = mk(K_ERR, 4'd0, 16'd0, len_ff, E_LONG_ID, line_ff);
               else if (hit)            fl.a = mk(K_KW, kwi, 16'd0, len_ff, E_NONE, line_ff);
               else                     fl.a = mk(K_ID, 4'd0, 16'd0, len_ff, E_NONE, line_ff);
            end
            ST_INT: begin
               fl.n = 2'd1;
               if (acc_ff > {1'b0, cfg.max_int})
                  fl.a = mk(K_ERR, 4'd0, 16'd0, 8'd0, E_INT_OVF, line_ff);
               else
                  fl.a = mk(K_INT, 4'd0, acc_ff[15:0], 8'd0, E_NONE, line_ff);
            end
            ST_REAL:    begin fl.n = 2'd1; fl.a = mk(K_REAL, 4'd0, 16'd0, 8'd0, E_NONE, line_ff); end
            ST_PLUS:    begin fl.n = 2'd1; fl.a = mk(K_PLUS, 4'd0, 16'd0, 8'd0, E_NONE, line_ff); end
            ST_ASSIGN:  begin fl.n = 2'd1; fl.a = mk(K_ASSIGN, 4'd0, 16'd0, 8'd0, E_NONE, line_ff); end
            ST_LESS:    begin fl.n = 2'd1; fl.a = mk(K_LT, 4'd0, 16'd0, 8'd0, E_NONE, line_ff); end
            ST_GREATER: begin fl.n = 2'd1; fl.a = mk(K_GT, 4'd0, 16'd0, 8'd0, E_NONE, line_ff); end
            ST_BANG:    begin fl.n = 2'd1; fl.a = mk(K_NOT, 4'd0, 16'd0, 8'd0, E_NONE, line_ff); end
            ST_MINUS:   begin fl.n = 2'd1; fl.a = mk(K_MINUS, 4'd0, 16'd0, 8'd0, E_NONE, line_ff); end
            ST_MINUS2:  begin fl.n = 2'd2; fl.a = mk(K_MINUS, 4'd0, 16'd0, 8'd0, E_NONE, line_ff); end
            ST_STR_DONE: begin
               fl.n = 2'd1;
               if (len_ff > cfg.max_str) fl.a = mk(K_ERR, 4'd0, 16'd0, len_ff, E_LONG_STR, line_ff);
               else                      fl.a = mk(K_STR, 4'd0, 16'd0, len_ff, E_NONE, line_ff);
            end
            ST_BAD: begin fl.n = 2'd1; fl.a = mk(K_ERR, 4'd0, 16'd0, 8'd0, E_BAD, line_ff); end
            default: fl.n = 2'd0;
         endcase
      end
   end

   // scan the current character from the start state
   always_comb begin
      sc.st  = ST_BAD;
      sc.kwb = '0;
      sc.len = 8'd0;
      sc.acc = 17'd0;
      if (is_let) begin
         sc.st  = ST_ID;
         sc.kwb = filt('1, 8'd0, lc);
         sc.len = 8'd1;
      end else if (is_dig) begin
         sc.st  = ST_INT;
         sc.acc = {13'd0, in_char[3:0]};
      end else begin
         case (in_char)
            "+": sc.st = ST_PLUS;
            "-": sc.st = ST_MINUS;
            "*": sc.st = ST_DONE | {1'b0, K_MUL};
            "/": sc.st = ST_DONE | {1'b0, K_DIV};
            "=": sc.st = ST_ASSIGN;
            "<": sc.st = ST_LESS;
            ">": sc.st = ST_GREATER;
            "!": sc.st = ST_BANG;
            ":": sc.st = ST_DONE | {1'b0, K_COLON};
            ";": sc.st = ST_DONE | {1'b0, K_SEMI};
            "(": sc.st = ST_DONE | {1'b0, K_LPAR};
            ")": sc.st = ST_DONE | {1'b0, K_RPAR};
            ",": sc.st = ST_DONE | {1'b0, K_COMMA};
            "{": sc.st = ST_DONE | {1'b0, K_LBRACE};
            "}": sc.st = ST_DONE | {1'b0, K_RBRACE};
            "\"": sc.st = ST_STR;
            ".": sc.st = ST_REAL;
            "?", " ", 8'h09, 8'h0D, 8'h0A: sc.st = ST_START;
            default: sc.st = ST_BAD;
         endcase
      end
   end

   // next state and emitted tokens
   always_comb begin
      st_in   = st_ff;
      kwb_in  = kwb_ff;
      len_in  = len_ff;
      acc_in  = acc_ff;
      line_in = line_ff;
      take    = 1'b0;
      n       = 2'd0;
      t0      = fl.a;
      t1      = fl.b;
      if (in_eoi) begin
         if (st_ff == ST_STR) begin
            n  = 2'd1;
            t0 = mk(K_ERR, 4'd0, 16'd0, 8'd0, E_EOF_STR, line_ff);
         end else if (st_ff >= ST_CM && st_ff <= ST_NC_SLM) begin
            n  = 2'd1;
            t0 = mk(K_ERR, 4'd0, 16'd0, 8'd0, E_EOF_CM, line_ff);
         end else begin
            n = fl.n;
         end
         st_in   = ST_START;
         kwb_in  = '0;
         len_in  = 8'd0;
         acc_in  = 17'd0;
         line_in = 16'd0;
      end else begin
         case (st_ff)
            ST_ID:
               if (is_let || is_dig) begin
                  kwb_in = filt(kwb_ff, len_ff, lc);
                  if (len_ff != 8'hFF) len_in = len_ff + 8'd1;
               end else take = 1'b1;
            ST_INT:
               if (is_dig) acc_in = (acc_mul > {3'd0, ACC_SAT}) ? ACC_SAT : acc_mul[16:0];
               else if (in_char == ".") st_in = ST_REAL;
               else take = 1'b1;
            ST_REAL:
               if (!is_dig) take = 1'b1;
            ST_STR:
               if (in_char == "\"") st_in = ST_STR_DONE;
               else if (len_ff != 8'hFF) len_in = len_ff + 8'd1;
            ST_PLUS:
               if (in_char == "+") st_in = ST_DONE | {1'b0, K_CONCAT};
               else take = 1'b1;
            ST_ASSIGN:
               if (in_char == "=") st_in = ST_DONE | {1'b0, K_EQ};
               else take = 1'b1;
            ST_LESS:
               if (in_char == "=") st_in = ST_DONE | {1'b0, K_LE};
               else take = 1'b1;
            ST_GREATER:
               if (in_char == "=") st_in = ST_DONE | {1'b0, K_GE};
               else take = 1'b1;
            ST_BANG:
               if (in_char == "=") st_in = ST_DONE | {1'b0, K_NE};
               else take = 1'b1;
            ST_MINUS:
               if (in_char == "-") st_in = ST_MINUS2;
               else take = 1'b1;
            ST_MINUS2:
               if (in_char == "/") st_in = ST_CM;
               else if (in_char == "-") begin
                  n  = 2'd1;
                  t0 = mk(K_MINUS, 4'd0, 16'd0, 8'd0, E_NONE, line_ff);
               end else take = 1'b1;
            ST_CM:
               st_in = (in_char == "-") ? ST_CM_M : (in_char == "/") ? ST_CM_SL : ST_CM;
            ST_CM_SL:
               st_in = (in_char == "-") ? ST_CM_SLM : (in_char == "/") ? ST_CM_SL : ST_CM;
            ST_CM_SLM:
               st_in = (in_char == "-") ? ST_START : (in_char == "/") ? ST_CM_SL : ST_CM;
            ST_CM_M:
               st_in = (in_char == "-") ? ST_CM_MM : ST_CM;
            ST_CM_MM:
               st_in = (in_char == "-") ? ST_CM_MM : (in_char == "/") ? ST_NC : ST_CM;
            ST_NC:
               st_in = (in_char == "/") ? ST_NC_SL : ST_NC;
            ST_NC_SL:
               st_in = (in_char == "-") ? ST_NC_SLM : (in_char == "/") ? ST_NC_SL : ST_NC;
            ST_NC_SLM:
               st_in = (in_char == "/") ? ST_NC_SL : (in_char == "-") ? ST_CM : ST_NC;
            default: take = 1'b1;
         endcase
         // end the pending lexeme and restart on this character
         if (take) begin
            n      = fl.n;
            st_in  = sc.st;
            kwb_in = sc.kwb;
            len_in = sc.len;
            acc_in = sc.acc;
         end
         if (in_char == 8'h0A) line_in = line_ff + 16'd1;
      end
      t0.last = (n == 2'd1);
      t1.last = 1'b1;
   end

   assign push_n = in_valid ? n : 2'd0;
   assign tok0   = t0;
   assign tok1   = t1;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_START;
         kwb_ff  <= '0;
         len_ff  <= 8'd0;
         acc_ff  <= 17'd0;
         line_ff <= 16'd0;
      end else if (in_valid) begin
         st_ff   <= st_in;
         kwb_ff  <= kwb_in;
         len_ff  <= len_in;
         acc_ff  <= acc_in;
         line_ff <= line_in;
      end
   end

   // end of input leaves the scanner at the start with no lines counted
   a_eoi_clears: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_eoi |=> st_ff == ST_START && line_ff == 16'd0)
      else $error("end of input did not clear scanner state");
   // integer accumulator never exceeds its saturation value
   a_acc_sat: assert property (@(posedge clock) disable iff (reset)
      acc_ff <= ACC_SAT)
      else $error("integer accumulator beyond saturation");
   // two tokens come only from a pending double minus
   a_two_tok: assert property (@(posedge clock) disable iff (reset)
      push_n == 2'd2 |-> st_ff == ST_MINUS2)
      else $error("double result outside double minus");
endmodule
`default_nettype wire

// ===== hw/rtl/tdts_queue.sv =====
// Result queue: takes up to two tokens a cycle, delivers one per transfer.
`default_nettype none
module tdts_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [1:0]                    push_n,
   input  wire tdts_pkg::tok_type             tok0,
   input  wire tdts_pkg::tok_type             tok1,
   input  wire logic                          pop,
   output logic [tdts_pkg::QCNT_W-1:0]        count,
   output tdts_pkg::tok_type                  head
);
   localparam int PW = tdts_pkg::QPTR_W;
   localparam int CW = tdts_pkg::QCNT_W;

   tdts_pkg::tok_type mem_ff [tdts_pkg::QDEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_pop;

   assign do_pop = pop && cnt_ff != '0;

   // advance pointers and occupancy
   always_comb begin
      wr_in  = wr_ff + PW'(push_n);
      rd_in  = rd_ff + PW'(do_pop);
      cnt_in = cnt_ff + CW'(push_n) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) mem_ff[wr_ff] <= tok0;
      if (push_n == 2'd2) mem_ff[wr_ff + PW'(1)] <= tok1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   assign count = cnt_ff;
   assign head  = mem_ff[rd_ff];

   // no push beyond capacity
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) + 32'(push_n) <= tdts_pkg::QDEPTH)
      else $error("result queue overflow");
   // occupancy tracks pointer distance
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      PW'(cnt_ff) == PW'(wr_ff - rd_ff))
      else $error("queue count and pointers disagree");
   // a pop with nothing to push lowers the count by one
   a_pop_dec: assert property (@(posedge clock) disable iff (reset)
      do_pop && push_n == 2'd0 |=> cnt_ff == $past(cnt_ff) - CW'(1))
      else $error("pop did not lower queue count");
endmodule
`default_nettype wire

// ===== hw/rtl/table_driven_token_scanner_core.sv =====
// Top level of the token scanner: input register, scanner, result queue, control port.
// One character (or end of input) is taken per cycle; a transfer on req_ takes effect
// in the scanner in the next cycle and its tokens (none, one or two) enter an eight-entry
// result queue, readable on rsp_ from the next cycle. Sustained rate is one item per
// cycle as long as rsp_ keeps pace; req_stall rises when the queue plus the item in
// the input register could leave no room for two more tokens. No clearing pass.
`default_nettype none
module table_driven_token_scanner_core #(
   parameter int NUM_KEYWORDS = 14
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_char_code,
   input  wire logic        req_end_of_input,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [4:0]       rsp_token_kind,
   output logic [3:0]       rsp_keyword_index,
   output logic [15:0]      rsp_int_value,
   output logic [7:0]       rsp_lexeme_length,
   output logic [2:0]       rsp_error_code,
   output logic [15:0]      rsp_line_number,
   output logic             rsp_last_result,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   localparam int CW = tdts_pkg::QCNT_W;

   tdts_pkg::cfg_type cfg;
   tdts_pkg::tok_type tok0, tok1, head;
   logic [1:0]        push_n;
   logic [CW-1:0]     count;
   logic              in_valid_ff;
   logic [7:0]        in_char_ff;
   logic              in_eoi_ff;
   logic              accept;

   // hold off while the queue could not absorb two more tokens
   assign req_stall = (32'(count) + (in_valid_ff ? 32'd2 : 32'd0)) > (tdts_pkg::QDEPTH - 2);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else       in_valid_ff <= accept;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_char_ff <= req_char_code;
         in_eoi_ff  <= req_end_of_input;
      end
   end

   tdts_csr u_csr (
      .clock(clock), .reset(reset),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready), .cfg(cfg)
   );

   tdts_lexer #(.NUM_KEYWORDS(NUM_KEYWORDS)) u_lexer (
      .clock(clock), .reset(reset),
      .in_valid(in_valid_ff), .in_char(in_char_ff), .in_eoi(in_eoi_ff),
      .cfg(cfg), .push_n(push_n), .tok0(tok0), .tok1(tok1)
   );

   tdts_queue u_queue (
      .clock(clock), .reset(reset),
      .push_n(push_n), .tok0(tok0), .tok1(tok1),
      .pop(!rsp_stall), .count(count), .head(head)
   );

   // drive the result channel from the queue head
   assign rsp_valid         = count != '0;
   assign rsp_token_kind    = head.kind;
   assign rsp_keyword_index = head.kw;
   assign rsp_int_value     = head.val;
   assign rsp_lexeme_length = head.len;
   assign rsp_error_code    = head.err;
   assign rsp_line_number   = head.line;
   assign rsp_last_result   = head.last;
endmodule
`default_nettype wire
